// ===== hw/rtl/fapm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fapm_pkg
// Shared constants and control types for the four-axis PID thruster mixer.
// ----------------------------------------------------------------------------
package fapm_pkg;

  localparam int NUM_AXES       = 4;
  localparam int DATA_WIDTH_DEF = 24;

  localparam int GAIN_W  = 16;
  localparam int SUM_W   = 18;
  localparam int BAL_W   = 32;
  localparam int SPEED_W = 16;
  localparam int FORCE_W = 36;
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 3;

  localparam int AX_ROLL  = 0;
  localparam int AX_PITCH = 1;
  localparam int AX_YAW   = 2;
  localparam int AX_HEAVE = 3;

  localparam int HALF_TURN_Q8 = 46080;
  localparam int FULL_TURN_Q8 = 92160;

  localparam logic [IDX_W-1:0] CFG_GAINS_ROLL      = 3'd0;
  localparam logic [IDX_W-1:0] CFG_GAINS_PITCH     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_GAINS_YAW       = 3'd2;
  localparam logic [IDX_W-1:0] CFG_GAINS_HEAVE     = 3'd3;
  localparam logic [IDX_W-1:0] CFG_INTEGRAL_LIMIT  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_DEADBAND_OFFSET = 3'd5;
  localparam logic [IDX_W-1:0] CFG_DEADBAND_BOUND  = 3'd6;

  localparam logic [15:0] INTEGRAL_LIMIT_RST  = 16'd653;
  localparam logic [7:0]  DEADBAND_OFFSET_RST = 8'd30;
  localparam logic [14:0] DEADBAND_BOUND_RST  = 15'd1530;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } lane_ctl_t;

  typedef struct packed {
    logic ld5;
    logic ld6;
  } mixer_ctl_t;

endpackage

// ===== hw/rtl/fapm_pid_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fapm_pid_lane
// One PID axis: error with optional heading wrap, clamped integral,
// derivative, three gain products and a floored, saturated balance.
// ----------------------------------------------------------------------------
module fapm_pid_lane #(
  parameter int DW   = fapm_pkg::DATA_WIDTH_DEF,
  parameter bit WRAP = 1'b0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fapm_pkg::lane_ctl_t                 ctl,
  input  logic signed [DW-1:0]                setpoint,
  input  logic signed [DW-1:0]                measure,
  input  logic        [fapm_pkg::CFG_W-1:0]   gains,
  input  logic        [15:0]                  lim,
  output logic signed [fapm_pkg::BAL_W-1:0]   bal
);
  import fapm_pkg::*;

  localparam int EW = DW + 1;
  localparam int XW = DW + 3;
  localparam int AW = DW + 20;
  localparam logic signed [XW-1:0] HALF_X = XW'(HALF_TURN_Q8);
  localparam logic signed [XW-1:0] FULL_X = XW'(FULL_TURN_Q8);
  localparam logic signed [63:0]   BAL_MAX = 64'sd2147483647;
  localparam logic signed [63:0]   BAL_MIN = -64'sd2147483648;

  logic signed [EW-1:0]     err_raw;
  logic signed [XW-1:0]     err_x;
  logic signed [XW-1:0]     err_wr;
  logic signed [EW-1:0]     err1_nxt;
  logic signed [EW-1:0]     err1_r;

  logic signed [EW-1:0]     prev_r;
  logic signed [SUM_W-1:0]  sum_r;

  logic signed [XW-1:0]     sum_x;
  logic signed [XW-1:0]     diff_x;
  logic signed [XW-1:0]     lim_x;
  logic signed [SUM_W-1:0]  sum_nxt;

  logic signed [EW-1:0]     err2_r;
  logic signed [DW+1:0]     diff2_r;
  logic signed [SUM_W-1:0]  sum2_r;

  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;

  logic signed [DW+16:0]    pkp_nxt;
  logic signed [33:0]       pki_nxt;
  logic signed [DW+17:0]    pkd_nxt;
  logic signed [DW+16:0]    pkp_r;
  logic signed [33:0]       pki_r;
  logic signed [DW+17:0]    pkd_r;

  logic signed [AW-1:0]     acc;
  logic signed [AW-1:0]     acc_sh;
  logic signed [63:0]       acc_x;
  logic signed [BAL_W-1:0]  bal_nxt;
  logic signed [BAL_W-1:0]  bal4_r;

  assign err_raw = EW'(setpoint) - EW'(measure);
  assign err_x   = XW'(err_raw);

  always_comb begin
    err_wr = err_x;
    if (WRAP) begin
      if (err_x > HALF_X) begin
        err_wr = err_x - FULL_X;
      end else if (err_x < -HALF_X) begin
        err_wr = err_x + FULL_X;
      end
    end
    err1_nxt = err_wr[EW-1:0];
  end

  assign lim_x  = XW'($signed({1'b0, lim}));
  assign sum_x  = XW'(sum_r) + XW'(err1_r);
  assign diff_x = XW'(err1_r) - XW'(prev_r);

  always_comb begin
    if (sum_x > lim_x) begin
      sum_nxt = SUM_W'(lim_x);
    end else if (sum_x < -lim_x) begin
      sum_nxt = SUM_W'(-lim_x);
    end else begin
      sum_nxt = SUM_W'(sum_x);
    end
  end

  assign kp = $signed(gains[15:0]);
  assign ki = $signed(gains[31:16]);
  assign kd = $signed(gains[47:32]);

  assign pkp_nxt = kp * err2_r;
  assign pki_nxt = ki * sum2_r;
  assign pkd_nxt = kd * diff2_r;

  assign acc    = AW'(pkp_r) + AW'(pki_r) + AW'(pkd_r);
  assign acc_sh = acc >>> 8;
  assign acc_x  = 64'(acc_sh);

  always_comb begin
    if (acc_x > BAL_MAX) begin
      bal_nxt = BAL_W'(BAL_MAX);
    end else if (acc_x < BAL_MIN) begin
      bal_nxt = BAL_W'(BAL_MIN);
    end else begin
      bal_nxt = BAL_W'(acc_x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      sum_r  <= '0;
    end else if (ctl.ld2) begin
      prev_r <= err1_r;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      err1_r <= err1_nxt;
    end
    if (ctl.ld2) begin
      err2_r  <= err1_r;
      diff2_r <= diff_x[DW+1:0];
      sum2_r  <= sum_nxt;
    end
    if (ctl.ld3) begin
      pkp_r <= pkp_nxt;
      pki_r <= pki_nxt;
      pkd_r <= pkd_nxt;
    end
    if (ctl.ld4) begin
      bal4_r <= bal_nxt;
    end
  end

  assign bal = bal4_r;

endmodule

// ===== hw/rtl/fapm_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fapm_mixer
// Merge the four axis balances with the base thrusts into six thruster
// forces, apply the deadband step and saturate each to a 16-bit speed.
// ----------------------------------------------------------------------------
module fapm_mixer (
  input  logic                                 clk,
  input  fapm_pkg::mixer_ctl_t                 ctl,
  input  logic signed [fapm_pkg::BAL_W-1:0]    bal_roll,
  input  logic signed [fapm_pkg::BAL_W-1:0]    bal_pitch,
  input  logic signed [fapm_pkg::BAL_W-1:0]    bal_yaw,
  input  logic signed [fapm_pkg::BAL_W-1:0]    bal_heave,
  input  logic signed [15:0]                   thrust_heave,
  input  logic signed [15:0]                   thrust_left,
  input  logic signed [15:0]                   thrust_right,
  input  logic signed [15:0]                   thrust_sway,
  input  logic        [7:0]                    db_offset,
  input  logic        [14:0]                   db_bound,
  output logic signed [fapm_pkg::SPEED_W-1:0]  speed [6],
  output logic signed [fapm_pkg::BAL_W-1:0]    bal_out [4]
);
  import fapm_pkg::*;

  function automatic logic signed [SPEED_W-1:0] make_speed(
    input logic signed [FORCE_W-1:0] f,
    input logic [14:0]               bound,
    input logic [7:0]                off
  );
    logic signed [FORCE_W-1:0] b;
    logic signed [FORCE_W-1:0] o;
    logic signed [FORCE_W-1:0] g;
    logic signed [FORCE_W-1:0] t;
    logic signed [FORCE_W-9:0] q;
    b = $signed({13'b0, bound, 8'b0});
    o = $signed({20'b0, off, 8'b0});
    g = f;
    if (!f[FORCE_W-1] && (f < b)) begin
      g = f + o;
    end else if (f[FORCE_W-1] && (f > -b)) begin
      g = f - o;
    end
    t = g[FORCE_W-1] ? (g + FORCE_W'(255)) : g;
    q = t[FORCE_W-1:8];
    if (q > (FORCE_W-8)'(32767)) begin
      make_speed = 16'sh7fff;
    end else if (q < -(FORCE_W-8)'(32768)) begin
      make_speed = 16'sh8000;
    end else begin
      make_speed = q[SPEED_W-1:0];
    end
  endfunction

  logic signed [FORCE_W-1:0] th;
  logic signed [FORCE_W-1:0] tl;
  logic signed [FORCE_W-1:0] tr;
  logic signed [FORCE_W-1:0] ts;
  logic signed [FORCE_W-1:0] br;
  logic signed [FORCE_W-1:0] bp;
  logic signed [FORCE_W-1:0] by;
  logic signed [FORCE_W-1:0] bh;
  logic signed [FORCE_W-1:0] f_nxt [6];
  logic signed [FORCE_W-1:0] f5_r  [6];
  logic signed [BAL_W-1:0]   bal5_r [4];
  logic signed [SPEED_W-1:0] speed6_r [6];
  logic signed [BAL_W-1:0]   bal6_r [4];

  assign th = FORCE_W'($signed({thrust_heave, 8'b0}));
  assign tl = FORCE_W'($signed({thrust_left, 8'b0}));
  assign tr = FORCE_W'($signed({thrust_right, 8'b0}));
  assign ts = FORCE_W'($signed({thrust_sway, 8'b0}));
  assign br = FORCE_W'(bal_roll);
  assign bp = FORCE_W'(bal_pitch);
  assign by = FORCE_W'(bal_yaw);
  assign bh = FORCE_W'(bal_heave);

  always_comb begin
    f_nxt[0] = th + bh - bp - br;
    f_nxt[1] = th + bh - bp + br;
    f_nxt[2] = th + bh + (bp <<< 1);
    f_nxt[3] = tl + by;
    f_nxt[4] = tr - by;
    f_nxt[5] = ts;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld5) begin
      f5_r          <= f_nxt;
      bal5_r[AX_ROLL]  <= bal_roll;
      bal5_r[AX_PITCH] <= bal_pitch;
      bal5_r[AX_YAW]   <= bal_yaw;
      bal5_r[AX_HEAVE] <= bal_heave;
    end
    if (ctl.ld6) begin
      for (int i = 0; i < 6; i++) begin
        speed6_r[i] <= make_speed(f5_r[i], db_bound, db_offset);
      end
      bal6_r <= bal5_r;
    end
  end

  assign speed   = speed6_r;
  assign bal_out = bal6_r;

endmodule

// ===== hw/rtl/four_axis_pid_thruster_mixer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_axis_pid_thruster_mixer_top
// Four PID lanes side by side feeding a six-thruster mixer stage.
//
//   channel | direction | transfer when         | payload
//   in_     | input     | in_valid & !in_stall  | setpoints, measures, thrusts
//   out_    | output    | out_valid & !out_stall| six speeds, four balances
//   cfg_    | input     | cfg_we                | cfg_index, cfg_data
//
// Six-stage pipeline: one transfer per cycle while out_stall is low.
// Each stage holds on its own, so a stalled output backs up only full stages.
// The per-axis integral and last error advance as an item leaves stage one.
// Reset is synchronous; it empties the pipeline and clears the axis state.
// ----------------------------------------------------------------------------
module four_axis_pid_thruster_mixer_top #(
  parameter int DATA_WIDTH = fapm_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [DATA_WIDTH-1:0]         in_setpoint_roll,
  input  logic signed [DATA_WIDTH-1:0]         in_measure_roll,
  input  logic signed [DATA_WIDTH-1:0]         in_setpoint_pitch,
  input  logic signed [DATA_WIDTH-1:0]         in_measure_pitch,
  input  logic signed [DATA_WIDTH-1:0]         in_setpoint_yaw,
  input  logic signed [DATA_WIDTH-1:0]         in_measure_yaw,
  input  logic signed [DATA_WIDTH-1:0]         in_setpoint_heave,
  input  logic signed [DATA_WIDTH-1:0]         in_measure_heave,
  input  logic signed [15:0]                   in_thrust_heave,
  input  logic signed [15:0]                   in_thrust_left,
  input  logic signed [15:0]                   in_thrust_right,
  input  logic signed [15:0]                   in_thrust_sway,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [fapm_pkg::SPEED_W-1:0]  out_speed_0,
  output logic signed [fapm_pkg::SPEED_W-1:0]  out_speed_1,
  output logic signed [fapm_pkg::SPEED_W-1:0]  out_speed_2,
  output logic signed [fapm_pkg::SPEED_W-1:0]  out_speed_3,
  output logic signed [fapm_pkg::SPEED_W-1:0]  out_speed_4,
  output logic signed [fapm_pkg::SPEED_W-1:0]  out_speed_5,
  output logic signed [fapm_pkg::BAL_W-1:0]    out_balance_roll,
  output logic signed [fapm_pkg::BAL_W-1:0]    out_balance_pitch,
  output logic signed [fapm_pkg::BAL_W-1:0]    out_balance_yaw,
  output logic signed [fapm_pkg::BAL_W-1:0]    out_balance_heave,
  input  logic                                 cfg_we,
  input  logic        [fapm_pkg::IDX_W-1:0]    cfg_index,
  input  logic        [fapm_pkg::CFG_W-1:0]    cfg_data
);
  import fapm_pkg::*;

  localparam int NST = 6;

  logic [CFG_W-1:0] gains_r [NUM_AXES];
  logic [15:0]      lim_r;
  logic [7:0]       db_offset_r;
  logic [14:0]      db_bound_r;

  logic [NST-1:0]   v_r;
  logic [NST-1:0]   v_nxt;
  logic [NST-1:0]   go;
  logic [NST-1:0]   prev_v;
  logic [NST-1:0]   ld;

  lane_ctl_t        lane_ctl;
  mixer_ctl_t       mix_ctl;

  logic signed [DATA_WIDTH-1:0] sp_a [NUM_AXES];
  logic signed [DATA_WIDTH-1:0] ms_a [NUM_AXES];
  logic signed [BAL_W-1:0]      bal_a [NUM_AXES];
  logic signed [15:0]           thr_r [4][4];
  logic signed [SPEED_W-1:0]    speed [6];
  logic signed [BAL_W-1:0]      bal_out [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        gains_r[i] <= '0;
      end
      lim_r       <= INTEGRAL_LIMIT_RST;
      db_offset_r <= DEADBAND_OFFSET_RST;
      db_bound_r  <= DEADBAND_BOUND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAINS_ROLL:      gains_r[AX_ROLL]  <= cfg_data;
        CFG_GAINS_PITCH:     gains_r[AX_PITCH] <= cfg_data;
        CFG_GAINS_YAW:       gains_r[AX_YAW]   <= cfg_data;
        CFG_GAINS_HEAVE:     gains_r[AX_HEAVE] <= cfg_data;
        CFG_INTEGRAL_LIMIT:  lim_r       <= cfg_data[15:0];
        CFG_DEADBAND_OFFSET: db_offset_r <= cfg_data[7:0];
        CFG_DEADBAND_BOUND:  db_bound_r  <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  assign prev_v = {v_r[NST-2:0], in_valid};

  always_comb begin
    go[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      go[k] = !v_r[k] || go[k+1];
    end
    ld    = go & prev_v;
    v_nxt = (go & prev_v) | (~go & v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall = !go[0];
  assign out_valid = v_r[NST-1];

  assign lane_ctl.ld1 = ld[0];
  assign lane_ctl.ld2 = ld[1];
  assign lane_ctl.ld3 = ld[2];
  assign lane_ctl.ld4 = ld[3];
  assign mix_ctl.ld5  = ld[4];
  assign mix_ctl.ld6  = ld[5];

  assign sp_a[AX_ROLL]  = in_setpoint_roll;
  assign ms_a[AX_ROLL]  = in_measure_roll;
  assign sp_a[AX_PITCH] = in_setpoint_pitch;
  assign ms_a[AX_PITCH] = in_measure_pitch;
  assign sp_a[AX_YAW]   = in_setpoint_yaw;
  assign ms_a[AX_YAW]   = in_measure_yaw;
  assign sp_a[AX_HEAVE] = in_setpoint_heave;
  assign ms_a[AX_HEAVE] = in_measure_heave;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    fapm_pid_lane #(
      .DW   (DATA_WIDTH),
      .WRAP (a == AX_YAW)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .setpoint (sp_a[a]),
      .measure  (ms_a[a]),
      .gains    (gains_r[a]),
      .lim      (lim_r),
      .bal      (bal_a[a])
    );
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      thr_r[0][0] <= in_thrust_heave;
      thr_r[0][1] <= in_thrust_left;
      thr_r[0][2] <= in_thrust_right;
      thr_r[0][3] <= in_thrust_sway;
    end
    for (int s = 1; s < 4; s++) begin
      if (ld[s]) begin
        thr_r[s] <= thr_r[s-1];
      end
    end
  end

  fapm_mixer u_mixer (
    .clk          (clk),
    .ctl          (mix_ctl),
    .bal_roll     (bal_a[AX_ROLL]),
    .bal_pitch    (bal_a[AX_PITCH]),
    .bal_yaw      (bal_a[AX_YAW]),
    .bal_heave    (bal_a[AX_HEAVE]),
    .thrust_heave (thr_r[3][0]),
    .thrust_left  (thr_r[3][1]),
    .thrust_right (thr_r[3][2]),
    .thrust_sway  (thr_r[3][3]),
    .db_offset    (db_offset_r),
    .db_bound     (db_bound_r),
    .speed        (speed),
    .bal_out      (bal_out)
  );

  assign out_speed_0       = speed[0];
  assign out_speed_1       = speed[1];
  assign out_speed_2       = speed[2];
  assign out_speed_3       = speed[3];
  assign out_speed_4       = speed[4];
  assign out_speed_5       = speed[5];
  assign out_balance_roll  = bal_out[AX_ROLL];
  assign out_balance_pitch = bal_out[AX_PITCH];
  assign out_balance_yaw   = bal_out[AX_YAW];
  assign out_balance_heave = bal_out[AX_HEAVE];

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_stall))
    else $error("input stalled with a free pipeline stage");

  a_out_from_stage5: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v_r[NST-1]) |-> $past(v_r[NST-2]))
    else $error("output valid without a feeding stage");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

endmodule
